@@ src/bmhq_pkg.sv @@
package bmhq_pkg;

    localparam int KIND_W        = 2;
    localparam int PAYLOAD_W     = 32;
    localparam int REQ_PRIO_W    = 32;
    localparam int ENTRY_COUNT_W = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    // Outcome of the shared compare unit: keep the current entry or take a candidate.
    typedef enum logic [1:0] {
        PICK_CUR = 2'd0,
        PICK_A   = 2'd1,
        PICK_B   = 2'd2
    } t_pick;

endpackage

@@ src/bmhq_req_if.sv @@
interface bmhq_req_if;

    logic                               valid;
    logic                               ready;
    logic [bmhq_pkg::KIND_W-1:0]        kind;
    logic [bmhq_pkg::PAYLOAD_W-1:0]     payload;
    logic [bmhq_pkg::REQ_PRIO_W-1:0]    priority_req;

    modport source (
        output valid,
        output kind,
        output payload,
        output priority_req,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  payload,
        input  priority_req,
        output ready
    );

endinterface

@@ src/bmhq_res_if.sv @@
interface bmhq_res_if;

    logic                                   valid;
    logic                                   ready;
    logic [bmhq_pkg::PAYLOAD_W-1:0]         out_payload;
    logic                                   out_valid;
    logic                                   dropped_full;
    logic                                   is_empty;
    logic [bmhq_pkg::ENTRY_COUNT_W-1:0]     entry_count;

    modport source (
        output valid,
        output out_payload,
        output out_valid,
        output dropped_full,
        output is_empty,
        output entry_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_payload,
        input  out_valid,
        input  dropped_full,
        input  is_empty,
        input  entry_count,
        output ready
    );

endinterface

@@ src/bmhq_ram.sv @@
module bmhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ src/bmhq_pick.sv @@
module bmhq_pick #(
    parameter int PW = 32
) (
    input  logic [PW-1:0]   i_cur_pri,
    input  logic [PW-1:0]   i_a_pri,
    input  logic            i_a_ok,
    input  logic [PW-1:0]   i_b_pri,
    input  logic            i_b_ok,
    output bmhq_pkg::t_pick o_sel
);

    logic          take_a;
    logic [PW-1:0] best_pri;
    logic          take_b;

    // Candidate A wins only when strictly smaller; B must then beat the running best,
    // so a tie between the two candidates stays with A.
    assign take_a   = i_a_ok && (i_a_pri < i_cur_pri);
    assign best_pri = take_a ? i_a_pri : i_cur_pri;
    assign take_b   = i_b_ok && (i_b_pri < best_pri);

    always_comb begin
        if (take_b) begin
            o_sel = bmhq_pkg::PICK_B;
        end else if (take_a) begin
            o_sel = bmhq_pkg::PICK_A;
        end else begin
            o_sel = bmhq_pkg::PICK_CUR;
        end
    end

endmodule

@@ src/binary_min_heap_queue.sv @@
// Channel   Port    Direction  Contents
// request   i_req   in         kind, payload, priority_req
// result    o_res   out        out_payload, out_valid, dropped_full, is_empty, entry_count
//
// An insert runs S_UP_RD and S_UP_CMP per level it rises; a remove runs S_DN_FETCH, then
// S_DN_RD and S_DN_CMP per level the moved entry sinks, none if it took the last entry.
// S_DONE registers every result; clear and no-ops go straight there. A level is one
// registered memory read and one comparator pass. Reset empties the queue at once and
// leaves stored entries alone. i_req.ready is high only while the sequencer is idle; a
// held result stalls only the next result, not the work on the request behind it.
module binary_min_heap_queue #(
    parameter int CAPACITY      = 512,
    parameter int PRIORITY_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_req_if.sink   i_req,
    bmhq_res_if.source o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int PW = PRIORITY_BITS;
    localparam int EW = bmhq_pkg::PAYLOAD_W + PRIORITY_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_FETCH,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pos, n_pos;
    logic [EW-1:0] r_cur, n_cur;
    logic [bmhq_pkg::PAYLOAD_W-1:0] r_rs_pay, n_rs_pay;
    logic r_rs_valid, n_rs_valid;
    logic r_rs_drop, n_rs_drop;

    logic r_o_vld, n_o_vld;
    logic [bmhq_pkg::PAYLOAD_W-1:0] r_o_pay, n_o_pay;
    logic r_o_valid, n_o_valid;
    logic r_o_drop, n_o_drop;
    logic r_o_empty, n_o_empty;
    logic [bmhq_pkg::ENTRY_COUNT_W-1:0] r_o_count, n_o_count;

    logic          we;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [EW-1:0] rd_data_a;
    logic [EW-1:0] rd_data_b;

    logic [AW-1:0] parent;
    logic [XW-1:0] lc_x;
    logic [XW-1:0] rc_x;
    logic          lc_ok;
    logic          rc_ok;

    logic [PW-1:0]   pk_cur;
    logic [PW-1:0]   pk_a;
    logic            pk_a_ok;
    logic [PW-1:0]   pk_b;
    logic            pk_b_ok;
    bmhq_pkg::t_pick pk_sel;

    assign parent = AW'((r_pos - AW'(1)) >> 1);
    assign lc_x   = XW'({r_pos, 1'b1});
    assign rc_x   = XW'({r_pos, 1'b0}) + XW'(2);
    assign lc_ok  = lc_x < XW'(r_cnt);
    assign rc_ok  = rc_x < XW'(r_cnt);

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Sifting up asks whether the held entry is strictly below its parent, so the parent
    // takes the role of the current entry there.
    always_comb begin
        if (r_state == S_UP_CMP) begin
            pk_cur  = rd_data_a[PW-1:0];
            pk_a    = r_cur[PW-1:0];
            pk_a_ok = 1'b1;
            pk_b    = rd_data_b[PW-1:0];
            pk_b_ok = 1'b0;
        end else begin
            pk_cur  = r_cur[PW-1:0];
            pk_a    = rd_data_a[PW-1:0];
            pk_a_ok = lc_ok;
            pk_b    = rd_data_b[PW-1:0];
            pk_b_ok = rc_ok;
        end
    end

    bmhq_pick #(
        .PW (PW)
    ) u_pick (
        .i_cur_pri (pk_cur),
        .i_a_pri   (pk_a),
        .i_a_ok    (pk_a_ok),
        .i_b_pri   (pk_b),
        .i_b_ok    (pk_b_ok),
        .o_sel     (pk_sel)
    );

    // The sift keeps a hole at r_pos and the moving entry in r_cur; it is written once at
    // the end, which leaves the same array as swapping at every level.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_rs_pay   = r_rs_pay;
        n_rs_valid = r_rs_valid;
        n_rs_drop  = r_rs_drop;
        n_o_vld    = r_o_vld;
        n_o_pay    = r_o_pay;
        n_o_valid  = r_o_valid;
        n_o_drop   = r_o_drop;
        n_o_empty  = r_o_empty;
        n_o_count  = r_o_count;
        we         = 1'b0;
        wr_addr    = r_pos;
        wr_data    = r_cur;
        rd_addr_a  = '0;
        rd_addr_b  = AW'(r_cnt - CW'(1));

        if (r_o_vld && o_res.ready) begin
            n_o_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_rs_pay   = '0;
                    n_rs_valid = 1'b0;
                    n_rs_drop  = 1'b0;
                    n_state    = S_DONE;
                    case (bmhq_pkg::t_kind'(i_req.kind))
                        bmhq_pkg::KIND_INSERT: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_rs_drop = 1'b1;
                            end else begin
                                n_cur   = {i_req.payload, i_req.priority_req[PW-1:0]};
                                n_pos   = AW'(r_cnt);
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        bmhq_pkg::KIND_REMOVE: begin
                            if (r_cnt != '0) begin
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_DN_FETCH;
                            end
                        end
                        bmhq_pkg::KIND_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                rd_addr_a = parent;
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (pk_sel == bmhq_pkg::PICK_A) begin
                    wr_data = rd_data_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_FETCH: begin
                n_rs_pay   = rd_data_a[EW-1:PW];
                n_rs_valid = 1'b1;
                n_cur      = rd_data_b;
                n_pos      = '0;
                n_state    = (r_cnt == '0) ? S_DONE : S_DN_RD;
            end
            S_DN_RD: begin
                rd_addr_a = lc_x[AW-1:0];
                rd_addr_b = rc_x[AW-1:0];
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                we = 1'b1;
                case (pk_sel)
                    bmhq_pkg::PICK_A: begin
                        wr_data = rd_data_a;
                        n_pos   = lc_x[AW-1:0];
                        n_state = S_DN_RD;
                    end
                    bmhq_pkg::PICK_B: begin
                        wr_data = rd_data_b;
                        n_pos   = rc_x[AW-1:0];
                        n_state = S_DN_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_o_vld || o_res.ready) begin
                    n_o_vld   = 1'b1;
                    n_o_pay   = r_rs_pay;
                    n_o_valid = r_rs_valid;
                    n_o_drop  = r_rs_drop;
                    n_o_empty = (r_cnt == '0);
                    n_o_count = bmhq_pkg::ENTRY_COUNT_W'(r_cnt);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_o_vld <= n_o_vld;
        end
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_rs_pay   <= n_rs_pay;
        r_rs_valid <= n_rs_valid;
        r_rs_drop  <= n_rs_drop;
        r_o_pay    <= n_o_pay;
        r_o_valid  <= n_o_valid;
        r_o_drop   <= n_o_drop;
        r_o_empty  <= n_o_empty;
        r_o_count  <= n_o_count;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_o_vld;
    assign o_res.out_payload  = r_o_pay;
    assign o_res.out_valid    = r_o_valid;
    assign o_res.dropped_full = r_o_drop;
    assign o_res.is_empty     = r_o_empty;
    assign o_res.entry_count  = r_o_count;

endmodule
